@@ rtl/lcd_mode_line_timing_macros.svh @@
// Assertion macros for the LCD mode and line timing block.
// Included by lmlt_core, the RTL file that checks its own logic; no other dependencies.
`ifndef LCD_MODE_LINE_TIMING_MACROS_SVH
`define LCD_MODE_LINE_TIMING_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define LMLT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lmlt same-cycle check failed");

// Next-cycle implication, disabled during reset
`define LMLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lmlt next-cycle check failed");

`else

`define LMLT_ASSERT_NOW(label, clk, rst, ante, cons)
`define LMLT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/lmlt_pkg.sv @@
// Shared types and timing constants for the LCD mode and line timing block.
// No dependencies; imported by every module of the block.
`default_nettype none

package lmlt_pkg;

   // Field widths
   localparam int DOTS_W = 6;
   localparam int DOT_W  = 10;
   localparam int LINE_W = 8;

   // Line timing in dot clocks and lines
   localparam logic [DOT_W-1:0]  DOTS_PER_LINE = 10'd456;
   localparam logic [DOT_W-1:0]  SCAN_END_DOT  = 10'd80;
   localparam logic [DOT_W-1:0]  DRAW_END_DOT  = 10'd252;
   localparam logic [DOT_W-1:0]  DOT_MAX       = 10'd1023;
   localparam logic [LINE_W-1:0] VBLANK_LINE   = 8'd144;
   localparam logic [LINE_W:0]   LAST_LINE     = 9'd153;

   // Register indexes on the configuration port
   localparam logic REG_LINE_COMPARE = 1'b0;
   localparam logic REG_IRQ_ENABLE   = 1'b1;

   // Display modes
   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_DRAW   = 2'd3
   } mode_type;

   // Configuration register contents
   typedef struct packed {
      logic [LINE_W-1:0] line_compare;
      logic              match_irq_enable;
   } cfg_type;

   // One result beat
   typedef struct packed {
      logic              render_request;
      logic              stat_irq;
      logic              vblank_irq;
      logic              match_flag;
      logic [LINE_W-1:0] cur_line;
      mode_type          cur_mode;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/lmlt_csr.sv @@
// Configuration registers of the LCD mode and line timing block, APB-style.
// Depends on lmlt_pkg for the register indexes and cfg_type.
`default_nettype none

module lmlt_csr
   import lmlt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   logic [LINE_W-1:0] line_compare_ff, line_compare_in;
   logic              irq_enable_ff, irq_enable_in;
   logic              wr_en;
   logic              reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   // Update the addressed register on the access cycle
   always_comb begin
      line_compare_in = line_compare_ff;
      irq_enable_in   = irq_enable_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_LINE_COMPARE: line_compare_in = csr_pwdata[LINE_W-1:0];
            REG_IRQ_ENABLE:   irq_enable_in   = csr_pwdata[0];
            default:          line_compare_in = line_compare_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_compare_ff <= '0;
         irq_enable_ff   <= 1'b0;
      end else begin
         line_compare_ff <= line_compare_in;
         irq_enable_ff   <= irq_enable_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (reg_sel)
         REG_LINE_COMPARE: csr_prdata = {{(32-LINE_W){1'b0}}, line_compare_ff};
         REG_IRQ_ENABLE:   csr_prdata = {31'd0, irq_enable_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   assign cfg.line_compare     = line_compare_ff;
   assign cfg.match_irq_enable = irq_enable_ff;

endmodule

`default_nettype wire

@@ rtl/lmlt_core.sv @@
// Dot counter, mode and line state with the per-beat next-state logic.
// Depends on lmlt_pkg and the assertion macros header.
`default_nettype none

`include "lcd_mode_line_timing_macros.svh"

module lmlt_core
   import lmlt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire logic [DOTS_W-1:0] dots,
   input  wire logic              lcd_enable,
   input  wire cfg_type           cfg,
   output result_type             res
);

   mode_type          mode_ff, mode_in;
   logic [DOT_W-1:0]  dot_ff, dot_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic              match_ff, match_in;

   logic [DOT_W:0]    dot_sum;
   logic [DOT_W-1:0]  dot_sat;
   logic [LINE_W:0]   line_inc;
   logic              line_change;
   logic              vblank_pulse;
   logic              render_pulse;

   // Add the elapsed dots and saturate at the counter top
   assign dot_sum  = {1'b0, dot_ff} + {{(DOT_W+1-DOTS_W){1'b0}}, dots};
   assign dot_sat  = dot_sum[DOT_W] ? DOT_MAX : dot_sum[DOT_W-1:0];
   assign line_inc = {1'b0, line_ff} + {{LINE_W{1'b0}}, 1'b1};

   // Make at most one mode change per beat
   always_comb begin
      mode_in      = mode_ff;
      dot_in       = dot_sat;
      line_in      = line_ff;
      line_change  = 1'b0;
      vblank_pulse = 1'b0;
      render_pulse = 1'b0;
      unique case (mode_ff)
         MODE_OAM: begin
            if (dot_sat >= SCAN_END_DOT) begin
               mode_in = MODE_DRAW;
            end
         end
         MODE_DRAW: begin
            if (dot_sat >= DRAW_END_DOT) begin
               mode_in      = MODE_HBLANK;
               render_pulse = 1'b1;
               if (!lcd_enable) begin
                  dot_in = '0;
               end
            end
         end
         MODE_HBLANK: begin
            if (dot_sat >= DOTS_PER_LINE) begin
               dot_in      = dot_sat - DOTS_PER_LINE;
               line_in     = line_inc[LINE_W-1:0];
               line_change = 1'b1;
               if (line_inc[LINE_W-1:0] == VBLANK_LINE) begin
                  mode_in      = MODE_VBLANK;
                  vblank_pulse = 1'b1;
               end else begin
                  mode_in = MODE_OAM;
               end
            end
         end
         MODE_VBLANK: begin
            if (dot_sat >= DOTS_PER_LINE) begin
               dot_in      = dot_sat - DOTS_PER_LINE;
               line_change = 1'b1;
               if (line_inc > LAST_LINE) begin
                  mode_in = MODE_OAM;
                  line_in = '0;
               end else begin
                  line_in = line_inc[LINE_W-1:0];
               end
            end
         end
         default: mode_in = mode_ff;
      endcase
   end

   // Compare the new line on each line change
   assign match_in = line_change ? (line_in == cfg.line_compare) : match_ff;

   // Advance the state once per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_HBLANK;
         dot_ff   <= '0;
         line_ff  <= '0;
         match_ff <= 1'b0;
      end else if (step_en) begin
         mode_ff  <= mode_in;
         dot_ff   <= dot_in;
         line_ff  <= line_in;
         match_ff <= match_in;
      end
   end

   assign res.cur_mode       = mode_in;
   assign res.cur_line       = line_in;
   assign res.match_flag     = match_in;
   assign res.vblank_irq     = vblank_pulse;
   assign res.stat_irq       = line_change & match_in & cfg.match_irq_enable;
   assign res.render_request = render_pulse;

   `LMLT_ASSERT_NOW(a_render_to_hblank, clock, reset, res.render_request,
                    res.cur_mode == MODE_HBLANK)
   `LMLT_ASSERT_NOW(a_vblank_entry, clock, reset, res.vblank_irq,
                    res.cur_mode == MODE_VBLANK && res.cur_line == VBLANK_LINE)
   `LMLT_ASSERT_NOW(a_stat_needs_match, clock, reset, res.stat_irq, res.match_flag)
   `LMLT_ASSERT_NEXT(a_hold_when_idle, clock, reset, !step_en,
                     $stable(dot_ff) && $stable(line_ff) && $stable(mode_ff))

endmodule

`default_nettype wire

@@ rtl/lcd_mode_line_timing.sv @@
// LCD mode and line timing block: use notes for the top level.
//
// Input stream (req_): each beat carries a count of dot clocks elapsed and
// the display enable bit. Result stream (rsp_): exactly one beat per input
// beat, carrying the mode and line after the step, the match flag, and the
// vblank, status and render request pulses.
// Configuration (csr_): APB-style; line_compare at 0x0, match_irq_enable
// at 0x4. Write registers only while no beat is in flight.
// Path: a beat is held in the input register, and its result in the result
// register; one beat per cycle while rsp_tready is high. The dot counter,
// mode and line update by combinational add, compare and select between
// input and result registers. The result register lets a new beat enter
// while the previous result waits on rsp_tready; when the receiver stalls,
// both registers fill and req_tready drops until the result is taken.
// Reset: synchronous; clears the stage valids, the configuration, and the
// state to horizontal blank, line 0, dot counter 0, match flag clear.
// Depends on lmlt_pkg, lmlt_csr and lmlt_core.
`default_nettype none

module lcd_mode_line_timing
   import lmlt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: [5:0] dots, [6] lcd_enable, [7] zero
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   // rsp_tdata: [1:0] cur_mode, [9:2] cur_line, [10] match_flag,
   // [11] vblank_irq, [12] stat_irq, [13] render_request, [15:14] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cfg_type           cfg;
   result_type        res;

   logic              in_valid_ff, in_valid_in;
   logic [DOTS_W-1:0] in_dots_ff;
   logic              in_enable_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        out_res_ff;

   logic              req_fire;
   logic              out_open;
   logic              step_en;

   lmlt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lmlt_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .dots       (in_dots_ff),
      .lcd_enable (in_enable_ff),
      .cfg        (cfg),
      .res        (res)
   );

   // Handshake between the input and result registers
   assign out_open   = !out_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && out_open;
   assign req_tready = !in_valid_ff || out_open;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire ? 1'b1 : (step_en ? 1'b0 : in_valid_ff);
   assign out_valid_in = step_en ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   // Hold the stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the input beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_dots_ff   <= req_tdata[DOTS_W-1:0];
         in_enable_ff <= req_tdata[DOTS_W];
      end
   end

   // Capture the result beat
   always_ff @(posedge clock) begin
      if (step_en) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_res_ff};

endmodule

`default_nettype wire
